// File: design/assert_macros.svh
// Assertion macros used by the RTL of the missing packet tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: design/mpt_pkg.sv
// Package with shared constants and types of the missing packet tracker.
`default_nettype none
package mpt_pkg;

   localparam int PKT_BITS       = 8;
   localparam int SEQ_BITS_DEF   = 8;
   localparam int MAX_LISTED_DEF = 63;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_MISSING = 1'b1;

   typedef struct packed {
      logic clearing;
      logic q_pop;
   } mpt_back_status_type;

endpackage
`default_nettype wire

// File: design/mpt_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module mpt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] wa,
   input  wire logic [WIDTH-1:0]         wd,
   input  wire logic [$clog2(DEPTH)-1:0] ra,
   output logic      [WIDTH-1:0]         rd
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rd_ff <= mem_ff[ra];
   end

   assign rd = rd_ff;

endmodule
`default_nettype wire

// File: design/mpt_front.sv
// Front end: accepts packet numbers, tracks the seen range and queues work.
`default_nettype none
module mpt_front import mpt_pkg::*; #(
   parameter int SEQ_BITS = SEQ_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [PKT_BITS-1:0] req_packet_number,
   input  wire logic                push,
   output logic                     full,
   input  wire mpt_back_status_type back_status,
   output logic                     q_vld,
   output logic [SEQ_BITS-1:0]      q_n,
   output logic [SEQ_BITS-1:0]      q_lo,
   output logic [SEQ_BITS-1:0]      q_hi
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

   logic [SEQ_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                any_ff;
   logic [SEQ_BITS-1:0] n;
   logic                accept;

   logic [SEQ_BITS-1:0] n_q_ff  [QUEUE_DEPTH];
   logic [SEQ_BITS-1:0] lo_q_ff [QUEUE_DEPTH];
   logic [SEQ_BITS-1:0] hi_q_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   assign n      = SEQ_BITS'(req_packet_number);
   assign full   = (cnt_ff == CNT_BITS'(QUEUE_DEPTH)) || back_status.clearing;
   assign accept = push && !full;

   // Widen the seen range; the first packet sets both ends.
   always_comb begin
      if (!any_ff) begin
         lo_in = n;
         hi_in = n;
      end else begin
         lo_in = (n < lo_ff) ? n : lo_ff;
         hi_in = (n > hi_ff) ? n : hi_ff;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept && !back_status.q_pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (!accept && back_status.q_pop) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff     <= '0;
         hi_ff     <= '0;
         any_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            lo_ff     <= lo_in;
            hi_ff     <= hi_in;
            any_ff    <= 1'b1;
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (back_status.q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_q_ff[wr_ptr_ff]  <= n;
         lo_q_ff[wr_ptr_ff] <= lo_in;
         hi_q_ff[wr_ptr_ff] <= hi_in;
      end
   end

   assign q_vld = (cnt_ff != '0);
   assign q_n   = n_q_ff[rd_ptr_ff];
   assign q_lo  = lo_q_ff[rd_ptr_ff];
   assign q_hi  = hi_q_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// File: design/mpt_back.sv
// Back end: marks the bitmap, scans the range and emits header and gap items.
`default_nettype none
module mpt_back import mpt_pkg::*; #(
   parameter int SEQ_BITS   = SEQ_BITS_DEF,
   parameter int MAX_LISTED = MAX_LISTED_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_vld,
   input  wire logic [SEQ_BITS-1:0] q_n,
   input  wire logic [SEQ_BITS-1:0] q_lo,
   input  wire logic [SEQ_BITS-1:0] q_hi,
   output mpt_back_status_type      back_status,
   output logic                     rsp_item_kind,
   output logic [PKT_BITS-1:0]      rsp_range_low,
   output logic [PKT_BITS-1:0]      rsp_range_high,
   output logic                     rsp_all_received,
   output logic                     rsp_list_truncated,
   output logic [PKT_BITS-1:0]      rsp_missing_number,
   output logic                     rsp_last_of_run,
   output logic                     empty,
   input  wire logic                pop
);

   localparam int ADDR_BITS = SEQ_BITS + 1;
   localparam int CNT_BITS  = $clog2(MAX_LISTED + 2);
   localparam logic [CNT_BITS-1:0]  MAX_CNT   = CNT_BITS'(MAX_LISTED);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'((2 ** SEQ_BITS) - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_COUNT  = 3'd2;
   localparam logic [2:0] ST_HEADER = 3'd3;
   localparam logic [2:0] ST_LIST   = 3'd4;

   logic [2:0]           st_ff, st_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [SEQ_BITS-1:0]  chk_ff, chk_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [SEQ_BITS-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in, listed_ff, listed_in;
   logic [CNT_BITS-1:0]  listed_next, target;

   logic                 out_vld_ff;
   logic                 kind_ff, all_ff, trunc_ff, last_ff;
   logic [PKT_BITS-1:0]  rlo_ff, rhi_ff, miss_ff;

   logic                 ram_we;
   logic [SEQ_BITS-1:0]  ram_wa, ram_ra;
   logic [0:0]           ram_wd, ram_rd;

   logic issuing, missing, slot_free, load_hdr, load_miss, q_pop;

   mpt_ram #(
      .WIDTH (1),
      .DEPTH (2 ** SEQ_BITS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .wa    (ram_wa),
      .wd    (ram_wd),
      .ra    (ram_ra),
      .rd    (ram_rd)
   );

   assign issuing     = (addr_ff <= {1'b0, hi_ff});
   assign missing     = chk_vld_ff && !ram_rd[0];
   assign slot_free   = !out_vld_ff || pop;
   assign listed_next = listed_ff + CNT_BITS'(1);
   assign target      = (cnt_ff > MAX_CNT) ? MAX_CNT : cnt_ff;

   always_comb begin
      st_in      = st_ff;
      addr_in    = addr_ff;
      chk_in     = chk_ff;
      chk_vld_in = chk_vld_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      cnt_in     = cnt_ff;
      listed_in  = listed_ff;
      ram_we     = 1'b0;
      ram_wa     = addr_ff[SEQ_BITS-1:0];
      ram_wd     = 1'b0;
      ram_ra     = addr_ff[SEQ_BITS-1:0];
      q_pop      = 1'b0;
      load_hdr   = 1'b0;
      load_miss  = 1'b0;
      unique case (st_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               st_in   = ST_IDLE;
               addr_in = '0;
            end else begin
               addr_in = addr_ff + ADDR_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (q_vld) begin
               ram_we     = 1'b1;
               ram_wa     = q_n;
               ram_wd     = 1'b1;
               q_pop      = 1'b1;
               lo_in      = q_lo;
               hi_in      = q_hi;
               addr_in    = {1'b0, q_lo};
               chk_vld_in = 1'b0;
               cnt_in     = '0;
               st_in      = ST_COUNT;
            end
         end
         ST_COUNT: begin
            chk_in     = addr_ff[SEQ_BITS-1:0];
            chk_vld_in = issuing;
            if (issuing) begin
               addr_in = addr_ff + ADDR_BITS'(1);
            end
            if (missing && cnt_ff <= MAX_CNT) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
            if ((!chk_vld_ff && !issuing) || cnt_ff > MAX_CNT) begin
               st_in = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (slot_free) begin
               load_hdr   = 1'b1;
               addr_in    = {1'b0, lo_ff};
               chk_vld_in = 1'b0;
               listed_in  = '0;
               st_in      = (cnt_ff == '0) ? ST_IDLE : ST_LIST;
            end
         end
         ST_LIST: begin
            if (missing && !slot_free) begin
               // Hold: re-read the pending entry until the output drains.
               ram_ra = chk_ff;
            end else begin
               chk_in     = addr_ff[SEQ_BITS-1:0];
               chk_vld_in = issuing;
               if (issuing) begin
                  addr_in = addr_ff + ADDR_BITS'(1);
               end
               if (missing) begin
                  load_miss = 1'b1;
                  listed_in = listed_next;
                  if (listed_next == target) begin
                     st_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_CLEAR;
         addr_ff    <= '0;
         chk_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         addr_ff    <= addr_in;
         chk_vld_ff <= chk_vld_in;
         if (load_hdr || load_miss) begin
            out_vld_ff <= 1'b1;
         end else if (pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_ff    <= chk_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      cnt_ff    <= cnt_in;
      listed_ff <= listed_in;
      if (load_hdr) begin
         kind_ff  <= KIND_HEADER;
         rlo_ff   <= PKT_BITS'(lo_ff);
         rhi_ff   <= PKT_BITS'(hi_ff);
         all_ff   <= (cnt_ff == '0);
         trunc_ff <= (cnt_ff > MAX_CNT);
         miss_ff  <= '0;
         last_ff  <= (cnt_ff == '0);
      end else if (load_miss) begin
         kind_ff  <= KIND_MISSING;
         rlo_ff   <= '0;
         rhi_ff   <= '0;
         all_ff   <= 1'b0;
         trunc_ff <= 1'b0;
         miss_ff  <= PKT_BITS'(chk_ff);
         last_ff  <= (listed_next == target);
      end
   end

   assign back_status.clearing = (st_ff == ST_CLEAR);
   assign back_status.q_pop    = q_pop;

   assign empty              = !out_vld_ff;
   assign rsp_item_kind      = kind_ff;
   assign rsp_range_low      = rlo_ff;
   assign rsp_range_high     = rhi_ff;
   assign rsp_all_received   = all_ff;
   assign rsp_list_truncated = trunc_ff;
   assign rsp_missing_number = miss_ff;
   assign rsp_last_of_run    = last_ff;

endmodule
`default_nettype wire

// File: design/missing_packet_tracker_core.sv
// Top level of the missing packet tracker: front end, work queue and scan back end.
`default_nettype none
`include "assert_macros.svh"
// Each packet number pushed in is marked in a received bitmap, and the block
// answers with a header item (lowest and highest number seen, an all-received
// flag and a truncated flag) followed by up to MAX_LISTED missing numbers in
// ascending order; the last item of each answer has last_of_run set. The front
// end updates the seen range at once and queues up to two packets, so pushes
// are taken while the back end is busy or a result waits to be popped. After
// reset the bitmap is swept to zero, one entry per cycle, with full held high.
// Per packet the back end marks the bitmap, counts the gaps over the range of
// high - low + 1 numbers (stopping once MAX_LISTED + 1 gaps are found), emits
// the header and then lists the gaps; the bitmap RAM has a single read port
// and is walked one entry per cycle while the result side does not stall.
module missing_packet_tracker_core import mpt_pkg::*; #(
   parameter int SEQ_BITS   = SEQ_BITS_DEF,
   parameter int MAX_LISTED = MAX_LISTED_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [PKT_BITS-1:0] req_packet_number,
   input  wire logic                push,
   output logic                     full,
   output logic                     rsp_item_kind,
   output logic [PKT_BITS-1:0]      rsp_range_low,
   output logic [PKT_BITS-1:0]      rsp_range_high,
   output logic                     rsp_all_received,
   output logic                     rsp_list_truncated,
   output logic [PKT_BITS-1:0]      rsp_missing_number,
   output logic                     rsp_last_of_run,
   output logic                     empty,
   input  wire logic                pop
);

   // Queue head handed from the front end to the back end.
   logic                q_vld;
   logic [SEQ_BITS-1:0] q_n, q_lo, q_hi;
   mpt_back_status_type back_status;

   // A header on offer whose last flag disagrees with its all-received flag.
   logic                header_flags_off;

   // Accept items and keep the seen range; hold them in a short queue.
   mpt_front #(
      .SEQ_BITS (SEQ_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_packet_number (req_packet_number),
      .push              (push),
      .full              (full),
      .back_status       (back_status),
      .q_vld             (q_vld),
      .q_n               (q_n),
      .q_lo              (q_lo),
      .q_hi              (q_hi)
   );

   // Mark the bitmap, count the gaps, then emit the header and the gap list.
   mpt_back #(
      .SEQ_BITS   (SEQ_BITS),
      .MAX_LISTED (MAX_LISTED)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_vld              (q_vld),
      .q_n                (q_n),
      .q_lo               (q_lo),
      .q_hi               (q_hi),
      .back_status        (back_status),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_range_low      (rsp_range_low),
      .rsp_range_high     (rsp_range_high),
      .rsp_all_received   (rsp_all_received),
      .rsp_list_truncated (rsp_list_truncated),
      .rsp_missing_number (rsp_missing_number),
      .rsp_last_of_run    (rsp_last_of_run),
      .empty              (empty),
      .pop                (pop)
   );

   assign header_flags_off = !empty && (rsp_item_kind == KIND_HEADER) &&
                             (rsp_last_of_run != rsp_all_received);

   // The back end takes an item only when the queue holds one.
   `ASSERT_PROP(a_pop_needs_item, clock, reset, back_status.q_pop |-> q_vld, "pop while empty")
   // No result is offered while the bitmap is being cleared.
   `ASSERT_PROP(a_quiet_clear, clock, reset, back_status.clearing |-> (empty && full), "busy in clear")
   // A header ends its run exactly when nothing is missing.
   `ASSERT_NEVER(a_header_last, clock, reset, header_flags_off, "header last flag wrong")

endmodule
`default_nettype wire
